FILE: rtl/bmp565_pkg.sv
// ----------------------------------------------------------------------------
// bmp565_pkg
// Shared types, codes and helpers of the bitmap row to RGB565 converter.
// ----------------------------------------------------------------------------
package bmp565_pkg;

    localparam int DISPLAY_WIDTH_DEF = 240;
    localparam int PALETTE_DEPTH_DEF = 256;

    localparam int WIDTH_W     = 12;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 12;
    localparam int COUNT_W     = 4;
    localparam logic [COUNT_W-1:0] MAX_PIXELS = 4'd8;

    localparam logic [CFG_INDEX_W-1:0] REG_PIXEL_FORMAT = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'b1;

    localparam logic KIND_PALETTE = 1'b0;
    localparam logic KIND_DATA    = 1'b1;

    localparam logic [2:0] FMT_1BPP  = 3'd0;
    localparam logic [2:0] FMT_4BPP  = 3'd1;
    localparam logic [2:0] FMT_8BPP  = 3'd2;
    localparam logic [2:0] FMT_16BPP = 3'd3;
    localparam logic [2:0] FMT_24BPP = 3'd4;
    localparam logic [2:0] FMT_32BPP = 3'd5;

    localparam logic [2:0]         FORMAT_RESET = FMT_8BPP;
    localparam logic [WIDTH_W-1:0] WIDTH_RESET  = 12'd240;

    typedef enum logic [1:0] {
        SRC_BIT    = 2'd0,
        SRC_NIB    = 2'd1,
        SRC_IDX    = 2'd2,
        SRC_DIRECT = 2'd3
    } src_t;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        src_t               src;
        logic [7:0]         bits;
        logic [15:0]        direct;
    } item_t;

    typedef struct packed {
        logic       en;
        logic [7:0] idx_a;
        logic [7:0] idx_b;
    } rd_req_t;

    typedef struct packed {
        logic        en;
        logic [7:0]  idx;
        logic [23:0] rgb;
    } wr_req_t;

    function automatic logic [15:0] to565(input logic [23:0] rgb);
        return {rgb[23:19], rgb[15:10], rgb[7:3]};
    endfunction

endpackage

FILE: rtl/bmp565_palette.sv
// ----------------------------------------------------------------------------
// bmp565_palette
// Palette memory: one write port, two registered read ports, per-entry valid
// bits so that unwritten entries read as black.
// ----------------------------------------------------------------------------
module bmp565_palette #(
    parameter int PALETTE_DEPTH = bmp565_pkg::PALETTE_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  bmp565_pkg::wr_req_t wr_req,
    input  bmp565_pkg::rd_req_t rd_req,
    output logic [15:0]         pix_a,
    output logic [15:0]         pix_b
);
    import bmp565_pkg::*;

    localparam int AW = $clog2(PALETTE_DEPTH);
    localparam logic [8:0] DEPTH9 = 9'(PALETTE_DEPTH);

    logic [23:0]              mem [PALETTE_DEPTH];
    logic [PALETTE_DEPTH-1:0] valid_reg;
    logic [23:0]              rd_a_reg;
    logic [23:0]              rd_b_reg;
    logic                     ok_a_reg;
    logic                     ok_b_reg;
    logic                     wr_hit;
    logic                     in_a;
    logic                     in_b;

    assign wr_hit = wr_req.en && ({1'b0, wr_req.idx} < DEPTH9);
    assign in_a   = {1'b0, rd_req.idx_a} < DEPTH9;
    assign in_b   = {1'b0, rd_req.idx_b} < DEPTH9;

    always_ff @(posedge clk)
    begin
        if (wr_hit)
        begin
            mem[wr_req.idx[AW-1:0]] <= wr_req.rgb;
        end
        if (rd_req.en)
        begin
            rd_a_reg <= mem[rd_req.idx_a[AW-1:0]];
            rd_b_reg <= mem[rd_req.idx_b[AW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            ok_a_reg  <= 1'b0;
            ok_b_reg  <= 1'b0;
        end
        else
        begin
            if (wr_hit)
            begin
                valid_reg[wr_req.idx[AW-1:0]] <= 1'b1;
            end
            if (rd_req.en)
            begin
                ok_a_reg <= in_a && valid_reg[rd_req.idx_a[AW-1:0]];
                ok_b_reg <= in_b && valid_reg[rd_req.idx_b[AW-1:0]];
            end
        end
    end

    assign pix_a = ok_a_reg ? to565(rd_a_reg) : 16'h0000;
    assign pix_b = ok_b_reg ? to565(rd_b_reg) : 16'h0000;

endmodule

FILE: rtl/bmp565_unpack.sv
// ----------------------------------------------------------------------------
// bmp565_unpack
// Configuration registers, row counters and byte assembly. Works out how many
// pixels a word yields and issues the palette reads for it.
// ----------------------------------------------------------------------------
module bmp565_unpack #(
    parameter int DISPLAY_WIDTH = bmp565_pkg::DISPLAY_WIDTH_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_write,
    input  logic [bmp565_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [bmp565_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                   accept,
    input  logic                                   kind,
    input  logic                                   row_start,
    input  logic [7:0]                             data_byte,
    output bmp565_pkg::item_t                      item,
    output logic                                   item_load,
    output bmp565_pkg::rd_req_t                    rd_req
);
    import bmp565_pkg::*;

    localparam logic [WIDTH_W-1:0] DISP = WIDTH_W'(DISPLAY_WIDTH);

    localparam logic [1:0] PHASE_FIRST  = 2'd0;
    localparam logic [1:0] PHASE_SECOND = 2'd1;
    localparam logic [1:0] PHASE_THIRD  = 2'd2;
    localparam logic [1:0] PHASE_ALPHA  = 2'd3;

    logic [2:0]         format_reg;
    logic [WIDTH_W-1:0] width_reg;
    logic [WIDTH_W-1:0] cnt_reg;
    logic [1:0]         phase_reg;
    logic [15:0]        held_reg;

    logic [WIDTH_W-1:0] cnt0;
    logic [1:0]         phase0;
    logic [15:0]        held0;
    logic [WIDTH_W-1:0] limit;
    logic [WIDTH_W-1:0] room;
    logic               open;
    logic [COUNT_W-1:0] want;
    logic [COUNT_W-1:0] n;
    logic [1:0]         phase_next;
    logic [15:0]        held_next;
    logic               lookup;
    logic               data_acc;

    assign data_acc = accept && (kind == KIND_DATA);

    always_comb
    begin
        cnt0       = row_start ? '0 : cnt_reg;
        phase0     = row_start ? PHASE_FIRST : phase_reg;
        held0      = row_start ? '0 : held_reg;
        limit      = (width_reg < DISP) ? width_reg : DISP;
        open       = cnt0 < limit;
        room       = limit - cnt0;
        want       = '0;
        phase_next = phase0;
        held_next  = held0;
        lookup     = 1'b0;
        item.src    = SRC_IDX;
        item.bits   = data_byte;
        item.direct = '0;
        rd_req.idx_a = '0;
        rd_req.idx_b = '0;
        unique case (format_reg) inside
            FMT_1BPP:
            begin
                want         = MAX_PIXELS;
                item.src     = SRC_BIT;
                rd_req.idx_a = 8'd0;
                rd_req.idx_b = 8'd1;
                lookup       = 1'b1;
            end
            FMT_4BPP:
            begin
                want         = 4'd2;
                item.src     = SRC_NIB;
                rd_req.idx_a = {4'h0, data_byte[7:4]};
                rd_req.idx_b = {4'h0, data_byte[3:0]};
                lookup       = 1'b1;
            end
            FMT_8BPP:
            begin
                want         = 4'd1;
                rd_req.idx_a = data_byte;
                lookup       = 1'b1;
            end
            FMT_16BPP:
            begin
                item.src = SRC_DIRECT;
                if (phase0 == PHASE_FIRST)
                begin
                    held_next  = {8'h00, data_byte};
                    phase_next = PHASE_SECOND;
                end
                else
                begin
                    want        = 4'd1;
                    item.direct = {data_byte, held0[7:0]};
                    phase_next  = PHASE_FIRST;
                end
            end
            FMT_24BPP, FMT_32BPP:
            begin
                item.src = SRC_DIRECT;
                if (phase0 == PHASE_FIRST
                    || (phase0 == PHASE_ALPHA && format_reg == FMT_24BPP))
                begin
                    held_next  = {8'h00, data_byte};
                    phase_next = PHASE_SECOND;
                end
                else if (phase0 == PHASE_SECOND)
                begin
                    held_next  = {data_byte, held0[7:0]};
                    phase_next = PHASE_THIRD;
                end
                else if (phase0 == PHASE_THIRD)
                begin
                    want        = 4'd1;
                    item.direct = to565({data_byte, held0});
                    phase_next  = (format_reg == FMT_32BPP) ? PHASE_ALPHA : PHASE_FIRST;
                end
                else
                begin
                    phase_next = PHASE_FIRST;
                end
            end
            default:
            begin
            end
        endcase
        if (!open)
        begin
            n = '0;
        end
        else if (room < {{(WIDTH_W-COUNT_W){1'b0}}, want})
        begin
            n = room[COUNT_W-1:0];
        end
        else
        begin
            n = want;
        end
        item.count = n;
        rd_req.en  = data_acc && (n != '0) && lookup;
    end

    assign item_load = data_acc && (n != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            format_reg <= FORMAT_RESET;
            width_reg  <= WIDTH_RESET;
            cnt_reg    <= '0;
            phase_reg  <= PHASE_FIRST;
            held_reg   <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_PIXEL_FORMAT: format_reg <= cfg_data[2:0];
                    REG_IMAGE_WIDTH:  width_reg  <= cfg_data[WIDTH_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (data_acc)
            begin
                if (open)
                begin
                    cnt_reg   <= cnt0 + {{(WIDTH_W-COUNT_W){1'b0}}, n};
                    phase_reg <= phase_next;
                    held_reg  <= held_next;
                end
                else
                begin
                    cnt_reg   <= cnt0;
                    phase_reg <= phase0;
                    held_reg  <= held0;
                end
            end
        end
    end

endmodule

FILE: rtl/bmp565_serial.sv
// ----------------------------------------------------------------------------
// bmp565_serial
// Holds one word's pixel set and moves its pixels, one per cycle while the output
// is not stalled, into the output register.
// ----------------------------------------------------------------------------
module bmp565_serial (
    input  logic              clk,
    input  logic              rst_n,
    input  bmp565_pkg::item_t item,
    input  logic              item_load,
    input  logic [15:0]       pix_a,
    input  logic [15:0]       pix_b,
    output logic              ready,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [15:0]       pixel,
    output logic              last
);
    import bmp565_pkg::*;

    item_t       item_reg;
    logic        busy_reg;
    logic [2:0]  pos_reg;
    logic        out_valid_reg;
    logic [15:0] pixel_reg;
    logic        last_reg;

    logic        o_free;
    logic        move;
    logic        is_end;
    logic [15:0] cur;

    assign o_free = !out_valid_reg || !out_stall;
    assign move   = busy_reg && o_free;
    assign is_end = {1'b0, pos_reg} == (item_reg.count - 4'd1);
    assign ready  = !busy_reg || (move && is_end);

    always_comb
    begin
        case (item_reg.src)
            SRC_BIT:    cur = item_reg.bits[3'd7 - pos_reg] ? pix_b : pix_a;
            SRC_NIB:    cur = (pos_reg == 3'd0) ? pix_a : pix_b;
            SRC_IDX:    cur = pix_a;
            default:    cur = item_reg.direct;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (item_load && ready)
        begin
            item_reg <= item;
        end
        if (o_free && move)
        begin
            pixel_reg <= cur;
            last_reg  <= is_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_load && ready)
            begin
                busy_reg <= 1'b1;
                pos_reg  <= '0;
            end
            else if (move)
            begin
                if (is_end)
                begin
                    busy_reg <= 1'b0;
                end
                else
                begin
                    pos_reg <= pos_reg + 3'd1;
                end
            end
            if (o_free)
            begin
                out_valid_reg <= move;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign pixel     = pixel_reg;
    assign last      = last_reg;

endmodule

FILE: rtl/bmp_row_to_rgb565.sv
// ----------------------------------------------------------------------------
// bmp_row_to_rgb565
// Converts bitmap pixel row bytes (1/4/8 bpp palette, 16/24/32 bpp direct)
// into RGB565 pixel words.
//
//   channel  direction  handshake           payload
//   in       sink       in_valid/in_stall   kind, row_start, data_byte, palette_*
//   out      source     out_valid/out_stall pixel, last
//   cfg      sink       cfg_write           cfg_index, cfg_data
//
// A word yielding at most one pixel is taken every cycle while the output is not
// stalled; one yielding n pixels holds in_stall until its last pixel moves, as the
// output register moves one pixel per cycle when not stalled. Palette
// reads go through the registered memory port. Reset clears the palette valid
// bits at once: no clearing pass. out_stall holds the output register and, while
// the last pixel of a set waits to move, reaches in_stall in the same cycle.
// ----------------------------------------------------------------------------
module bmp_row_to_rgb565 #(
    parameter int DISPLAY_WIDTH = bmp565_pkg::DISPLAY_WIDTH_DEF,
    parameter int PALETTE_DEPTH = bmp565_pkg::PALETTE_DEPTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [bmp565_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bmp565_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               kind,
    input  logic                               row_start,
    input  logic [7:0]                         data_byte,
    input  logic [7:0]                         palette_index,
    input  logic [7:0]                         palette_red,
    input  logic [7:0]                         palette_green,
    input  logic [7:0]                         palette_blue,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [15:0]                        pixel,
    output logic                               last
);
    import bmp565_pkg::*;

    item_t       item;
    rd_req_t     rd_req;
    wr_req_t     wr_req;
    logic        item_load;
    logic        accept;
    logic        ready;
    logic [15:0] pix_a;
    logic [15:0] pix_b;

    assign in_stall = !ready;
    assign accept   = in_valid && ready;

    assign wr_req.en  = accept && (kind == KIND_PALETTE);
    assign wr_req.idx = palette_index;
    assign wr_req.rgb = {palette_red, palette_green, palette_blue};

    bmp565_unpack #(
        .DISPLAY_WIDTH (DISPLAY_WIDTH)
    ) u_unpack (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .kind      (kind),
        .row_start (row_start),
        .data_byte (data_byte),
        .item      (item),
        .item_load (item_load),
        .rd_req    (rd_req)
    );

    bmp565_palette #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_req (wr_req),
        .rd_req (rd_req),
        .pix_a  (pix_a),
        .pix_b  (pix_b)
    );

    bmp565_serial u_serial (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .item_load (item_load),
        .pix_a     (pix_a),
        .pix_b     (pix_b),
        .ready     (ready),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .pixel     (pixel),
        .last      (last)
    );

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        item_load |-> item.count <= MAX_PIXELS)
        else $error("pixel count of a word exceeds eight");

    a_read_source: assert property (@(posedge clk) disable iff (!rst_n)
        rd_req.en |-> item_load && item.src != SRC_DIRECT)
        else $error("palette read issued for a direct-colour word");

    a_port_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        wr_req.en |-> !rd_req.en)
        else $error("palette write and read in the same cycle");

endmodule
